/* design/rti_pkg.sv */
// Shared widths, register codes and the divider pipeline word for the
// ray/triangle intersection tester. No dependencies.
package rti_pkg;

	// Field and arithmetic widths.
	localparam int IN_W      = 21;   // Q8.12 coordinate
	localparam int S_W       = 22;   // origin minus vertex
	localparam int P_W       = 31;   // floored dir x AC
	localparam int Q_W       = 32;   // floored s x AB
	localparam int PROD_W    = 53;   // dot product term
	localparam int DOT_W     = 55;   // dot product sum
	localparam int MAG_W     = 54;   // magnitude of a dot product
	localparam int REM_W     = MAG_W + 1;
	localparam int TINT_W    = 15;   // integer bits of t
	localparam int FRAC_W    = 16;   // fraction bits of t, u and v
	localparam int TQ_W      = TINT_W + FRAC_W;
	localparam int DIV_STEPS = TQ_W;
	localparam int UV_START  = DIV_STEPS - FRAC_W;
	localparam int EPS_W     = 20;
	localparam int CFG_W     = 63;
	localparam int PADDR_W   = 5;
	localparam int PDATA_W   = 64;
	localparam int OUT_T_W   = 32;
	localparam int BARY_W    = 17;

	// Register indexes on the configuration port.
	typedef enum logic [1:0] {
		REG_VERTEX_A,
		REG_EDGE_AB,
		REG_EDGE_AC,
		REG_DET_EPS
	} reg_idx_t;

	// One word travelling through the divider pipeline.
	typedef struct packed {
		logic              miss;
		logic              tneg;
		logic              tsat;
		logic              u_one;
		logic              v_one;
		logic [MAG_W-1:0]  dm;
		logic [REM_W-1:0]  tr;
		logic [TQ_W-1:0]   tbits;
		logic [TQ_W-1:0]   tq;
		logic [REM_W-1:0]  ur;
		logic [REM_W-1:0]  vr;
		logic [FRAC_W-1:0] uq;
		logic [FRAC_W-1:0] vq;
	} div_word_t;

endpackage

/* design/rti_div.sv */
// Pipelined restoring divider for t, u and v, one quotient bit per stage.
// Depends on rti_pkg for widths and the divider word type.
module rti_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  rti_pkg::div_word_t in_word,
	output logic              in_adv,
	input  logic              out_adv,
	output logic              out_valid,
	output rti_pkg::div_word_t out_word
);
	import rti_pkg::*;

	// One long-division step; u and v only take part in the last stages.
	function automatic div_word_t div_step(input div_word_t w, input logic uv_on);
		div_word_t        r;
		logic [REM_W-1:0] tt;
		logic [REM_W-1:0] tu;
		logic [REM_W-1:0] tv;
		logic [REM_W-1:0] dd;
		r  = w;
		dd = REM_W'(w.dm);
		tt = {w.tr[REM_W-2:0], w.tbits[TQ_W-1]};
		r.tbits = {w.tbits[TQ_W-2:0], 1'b0};
		if (tt >= dd) begin
			r.tr = tt - dd;
			r.tq = {w.tq[TQ_W-2:0], 1'b1};
		end else begin
			r.tr = tt;
			r.tq = {w.tq[TQ_W-2:0], 1'b0};
		end
		if (uv_on) begin
			tu = {w.ur[REM_W-2:0], 1'b0};
			tv = {w.vr[REM_W-2:0], 1'b0};
			if (tu >= dd) begin
				r.ur = tu - dd;
				r.uq = {w.uq[FRAC_W-2:0], 1'b1};
			end else begin
				r.ur = tu;
				r.uq = {w.uq[FRAC_W-2:0], 1'b0};
			end
			if (tv >= dd) begin
				r.vr = tv - dd;
				r.vq = {w.vq[FRAC_W-2:0], 1'b1};
			end else begin
				r.vr = tv;
				r.vq = {w.vq[FRAC_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	logic              vld_s [DIV_STEPS];
	div_word_t         wrd_s [DIV_STEPS];
	logic [DIV_STEPS:0] adv;

	assign adv[DIV_STEPS] = out_adv;
	assign in_adv         = adv[0];
	assign out_valid      = vld_s[DIV_STEPS-1];
	assign out_word       = wrd_s[DIV_STEPS-1];

	// Each stage moves when it is empty or the next one moves.
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
		assign adv[k] = !vld_s[k] || adv[k+1];

		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (adv[k]) begin
					vld_s[k] <= in_valid;
				end
			end
			always_ff @(posedge clk) begin
				if (adv[k]) begin
					wrd_s[k] <= div_step(in_word, 1'b0);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (adv[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
			always_ff @(posedge clk) begin
				if (adv[k]) begin
					wrd_s[k] <= div_step(wrd_s[k-1], (k >= UV_START));
				end
			end
		end
	end

endmodule

/* design/ray_triangle_intersection_top.sv */
// Moller-Trumbore ray/triangle tester. An accepted word passes through seven
// arithmetic stages, 31 divider stages (one quotient bit each) and an output
// register. Throughput is one ray per cycle while out_stall is low; empty
// stages close up under a stall. Reset clears all valid bits and sets the
// triangle registers to zero and the epsilon register to 41.
module ray_triangle_intersection_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [rti_pkg::PADDR_W-1:0]       paddr,
	input  logic [rti_pkg::PDATA_W-1:0]       pwdata,
	output logic [rti_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [rti_pkg::IN_W-1:0]   origin_x,
	input  logic signed [rti_pkg::IN_W-1:0]   origin_y,
	input  logic signed [rti_pkg::IN_W-1:0]   origin_z,
	input  logic signed [rti_pkg::IN_W-1:0]   dir_x,
	input  logic signed [rti_pkg::IN_W-1:0]   dir_y,
	input  logic signed [rti_pkg::IN_W-1:0]   dir_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic signed [rti_pkg::OUT_T_W-1:0] dist_t,
	output logic [rti_pkg::BARY_W-1:0]        bary_u,
	output logic [rti_pkg::BARY_W-1:0]        bary_v
);
	import rti_pkg::*;

	// Configuration registers.
	logic [CFG_W-1:0] vtx_a_q;
	logic [CFG_W-1:0] edge_ab_q;
	logic [CFG_W-1:0] edge_ac_q;
	logic [EPS_W-1:0] eps_q;
	reg_idx_t         ridx;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[PADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_a_q   <= '0;
			edge_ab_q <= '0;
			edge_ac_q <= '0;
			eps_q     <= EPS_W'(41);
		end else if (psel && penable && pwrite && pready) begin
			case (ridx)
				REG_VERTEX_A: vtx_a_q   <= pwdata[CFG_W-1:0];
				REG_EDGE_AB:  edge_ab_q <= pwdata[CFG_W-1:0];
				REG_EDGE_AC:  edge_ac_q <= pwdata[CFG_W-1:0];
				REG_DET_EPS:  eps_q     <= pwdata[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (ridx)
			REG_VERTEX_A: prdata = PDATA_W'(vtx_a_q);
			REG_EDGE_AB:  prdata = PDATA_W'(edge_ab_q);
			REG_EDGE_AC:  prdata = PDATA_W'(edge_ac_q);
			REG_DET_EPS:  prdata = PDATA_W'(eps_q);
			default:      prdata = '0;
		endcase
	end

	// Unpacked triangle coordinates.
	logic signed [IN_W-1:0] va [3];
	logic signed [IN_W-1:0] e1 [3];
	logic signed [IN_W-1:0] e2 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			va[i] = $signed(vtx_a_q[IN_W*i +: IN_W]);
			e1[i] = $signed(edge_ab_q[IN_W*i +: IN_W]);
			e2[i] = $signed(edge_ac_q[IN_W*i +: IN_W]);
		end
	end

	// Stage handshake chain: a stage moves when empty or when the next moves.
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6, v7_s7, v39_s39;
	logic adv1, adv2, adv3, adv4, adv5, adv6, adv7, adv39;
	logic div_in_adv;
	logic div_out_valid;
	div_word_t div_out_word;

	assign adv39    = !v39_s39 || !out_stall;
	assign adv7     = !v7_s7 || div_in_adv;
	assign adv6     = !v6_s6 || adv7;
	assign adv5     = !v5_s5 || adv6;
	assign adv4     = !v4_s4 || adv5;
	assign adv3     = !v3_s3 || adv4;
	assign adv2     = !v2_s2 || adv3;
	assign adv1     = !v1_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1   <= 1'b0;
			v2_s2   <= 1'b0;
			v3_s3   <= 1'b0;
			v4_s4   <= 1'b0;
			v5_s5   <= 1'b0;
			v6_s6   <= 1'b0;
			v7_s7   <= 1'b0;
			v39_s39 <= 1'b0;
		end else begin
			if (adv1)  v1_s1   <= in_valid;
			if (adv2)  v2_s2   <= v1_s1;
			if (adv3)  v3_s3   <= v2_s2;
			if (adv4)  v4_s4   <= v3_s3;
			if (adv5)  v5_s5   <= v4_s4;
			if (adv6)  v6_s6   <= v5_s5;
			if (adv7)  v7_s7   <= v6_s6;
			if (adv39) v39_s39 <= div_out_valid;
		end
	end

	// Stage 1: capture the direction and form s = origin - A.
	logic signed [IN_W-1:0] dir_s1 [3];
	logic signed [S_W-1:0]  sv_s1  [3];

	always_ff @(posedge clk) begin
		if (adv1) begin
			dir_s1[0] <= dir_x;
			dir_s1[1] <= dir_y;
			dir_s1[2] <= dir_z;
			sv_s1[0]  <= S_W'(origin_x) - S_W'(va[0]);
			sv_s1[1]  <= S_W'(origin_y) - S_W'(va[1]);
			sv_s1[2]  <= S_W'(origin_z) - S_W'(va[2]);
		end
	end

	// Stage 2: the twelve cross-product terms.
	logic signed [2*IN_W-1:0] pm_s2 [6];
	logic signed [S_W+IN_W-1:0] qm_s2 [6];
	logic signed [IN_W-1:0] dir_s2 [3];
	logic signed [S_W-1:0]  sv_s2  [3];

	always_ff @(posedge clk) begin
		if (adv2) begin
			pm_s2[0] <= dir_s1[1] * e2[2];
			pm_s2[1] <= dir_s1[2] * e2[1];
			pm_s2[2] <= dir_s1[2] * e2[0];
			pm_s2[3] <= dir_s1[0] * e2[2];
			pm_s2[4] <= dir_s1[0] * e2[1];
			pm_s2[5] <= dir_s1[1] * e2[0];
			qm_s2[0] <= sv_s1[1] * e1[2];
			qm_s2[1] <= sv_s1[2] * e1[1];
			qm_s2[2] <= sv_s1[2] * e1[0];
			qm_s2[3] <= sv_s1[0] * e1[2];
			qm_s2[4] <= sv_s1[0] * e1[1];
			qm_s2[5] <= sv_s1[1] * e1[0];
			dir_s2   <= dir_s1;
			sv_s2    <= sv_s1;
		end
	end

	// Stage 3: cross-product differences, floored to 12 fraction bits.
	logic signed [2*IN_W:0]     pd [3];
	logic signed [S_W+IN_W:0]   qd [3];
	logic signed [P_W-1:0] p_s3 [3];
	logic signed [Q_W-1:0] q_s3 [3];
	logic signed [IN_W-1:0] dir_s3 [3];
	logic signed [S_W-1:0]  sv_s3  [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pd[i] = (2*IN_W+1)'(pm_s2[2*i]) - (2*IN_W+1)'(pm_s2[2*i+1]);
			qd[i] = (S_W+IN_W+1)'(qm_s2[2*i]) - (S_W+IN_W+1)'(qm_s2[2*i+1]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			for (int i = 0; i < 3; i++) begin
				p_s3[i] <= pd[i][2*IN_W:12];
				q_s3[i] <= qd[i][S_W+IN_W:12];
			end
			dir_s3 <= dir_s2;
			sv_s3  <= sv_s2;
		end
	end

	// Stage 4: the twelve dot-product terms.
	logic signed [PROD_W-1:0] dt_s4 [3];
	logic signed [PROD_W-1:0] ut_s4 [3];
	logic signed [PROD_W-1:0] vt_s4 [3];
	logic signed [PROD_W-1:0] tt_s4 [3];

	always_ff @(posedge clk) begin
		if (adv4) begin
			for (int i = 0; i < 3; i++) begin
				dt_s4[i] <= e1[i] * p_s3[i];
				ut_s4[i] <= sv_s3[i] * p_s3[i];
				vt_s4[i] <= dir_s3[i] * q_s3[i];
				tt_s4[i] <= e2[i] * q_s3[i];
			end
		end
	end

	// Stage 5: det, un, vn and tn sums.
	logic signed [DOT_W-1:0] det_s5, un_s5, vn_s5, tn_s5;

	always_ff @(posedge clk) begin
		if (adv5) begin
			det_s5 <= DOT_W'(dt_s4[0]) + DOT_W'(dt_s4[1]) + DOT_W'(dt_s4[2]);
			un_s5  <= DOT_W'(ut_s4[0]) + DOT_W'(ut_s4[1]) + DOT_W'(ut_s4[2]);
			vn_s5  <= DOT_W'(vt_s4[0]) + DOT_W'(vt_s4[1]) + DOT_W'(vt_s4[2]);
			tn_s5  <= DOT_W'(tt_s4[0]) + DOT_W'(tt_s4[1]) + DOT_W'(tt_s4[2]);
		end
	end

	// Stage 6: make the determinant positive, flipping the numerators with it.
	logic [MAG_W-1:0]        dm_s6;
	logic                    dzero_s6;
	logic signed [DOT_W-1:0] un_s6, vn_s6, tn_s6;
	logic                    dneg;

	assign dneg = det_s5[DOT_W-1];

	always_ff @(posedge clk) begin
		if (adv6) begin
			dm_s6    <= MAG_W'(dneg ? -det_s5 : det_s5);
			dzero_s6 <= (det_s5 == '0);
			un_s6    <= dneg ? -un_s5 : un_s5;
			vn_s6    <= dneg ? -vn_s5 : vn_s5;
			tn_s6    <= dneg ? -tn_s5 : tn_s5;
		end
	end

	// Stage 7: hit tests, t saturation and the divider start word.
	logic [MAG_W-1:0] tmag;
	logic [MAG_W:0]   uv_sum;
	logic             miss_c;
	div_word_t        w_c;
	div_word_t        w_s7;

	always_comb begin
		tmag   = MAG_W'(tn_s6[DOT_W-1] ? -tn_s6 : tn_s6);
		uv_sum = (MAG_W+1)'(un_s6[MAG_W-1:0]) + (MAG_W+1)'(vn_s6[MAG_W-1:0]);
		miss_c = dzero_s6
			|| (dm_s6 < MAG_W'({eps_q, 12'b0}))
			|| un_s6[DOT_W-1]
			|| (un_s6[MAG_W-1:0] > dm_s6)
			|| vn_s6[DOT_W-1]
			|| (uv_sum > (MAG_W+1)'(dm_s6));
		w_c.miss  = miss_c;
		w_c.tneg  = tn_s6[DOT_W-1];
		w_c.tsat  = MAG_W'(tmag[MAG_W-1:TINT_W]) >= dm_s6;
		w_c.u_one = (un_s6[MAG_W-1:0] == dm_s6);
		w_c.v_one = (vn_s6[MAG_W-1:0] == dm_s6);
		w_c.dm    = dm_s6;
		w_c.tr    = REM_W'(tmag[MAG_W-1:TINT_W]);
		w_c.tbits = {tmag[TINT_W-1:0], FRAC_W'(0)};
		w_c.tq    = '0;
		w_c.ur    = REM_W'(un_s6[MAG_W-1:0]);
		w_c.vr    = REM_W'(vn_s6[MAG_W-1:0]);
		w_c.uq    = '0;
		w_c.vq    = '0;
	end

	always_ff @(posedge clk) begin
		if (adv7) begin
			w_s7 <= w_c;
		end
	end

	// Stages 8 to 38: quotient bits of t, u and v.
	rti_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v7_s7),
		.in_word   (w_s7),
		.in_adv    (div_in_adv),
		.out_adv   (adv39),
		.out_valid (div_out_valid),
		.out_word  (div_out_word)
	);

	// Stage 39: result word with saturation, sign and miss zeroing.
	logic                      hit_s39;
	logic signed [OUT_T_W-1:0] dist_s39;
	logic [BARY_W-1:0]         u_s39, v_s39;
	logic [OUT_T_W-1:0]        tpos;
	logic [OUT_T_W-1:0]        tval;

	always_comb begin
		tpos = OUT_T_W'(div_out_word.tq);
		if (div_out_word.miss) begin
			tval = '0;
		end else if (div_out_word.tsat) begin
			tval = div_out_word.tneg ? {1'b1, {(OUT_T_W-1){1'b0}}}
			                         : {1'b0, {(OUT_T_W-1){1'b1}}};
		end else begin
			tval = div_out_word.tneg ? -tpos : tpos;
		end
	end

	always_ff @(posedge clk) begin
		if (adv39) begin
			hit_s39  <= !div_out_word.miss;
			dist_s39 <= $signed(tval);
			u_s39    <= div_out_word.miss  ? '0
			          : div_out_word.u_one ? {1'b1, FRAC_W'(0)}
			          : {1'b0, div_out_word.uq};
			v_s39    <= div_out_word.miss  ? '0
			          : div_out_word.v_one ? {1'b1, FRAC_W'(0)}
			          : {1'b0, div_out_word.vq};
		end
	end

	assign out_valid = v39_s39;
	assign hit       = hit_s39;
	assign dist_t    = dist_s39;
	assign bary_u    = u_s39;
	assign bary_v    = v_s39;

endmodule

/* design/rti_chk.sv */
// Port-level checks for the ray/triangle tester, bound to the top level.
// Depends on rti_pkg for port widths.
module rti_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic                               hit,
	input logic signed [rti_pkg::OUT_T_W-1:0] dist_t,
	input logic [rti_pkg::BARY_W-1:0]         bary_u,
	input logic [rti_pkg::BARY_W-1:0]         bary_v
);
	import rti_pkg::*;

	// A miss carries all-zero result fields.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> dist_t == '0 && bary_u == '0 && bary_v == '0)
		else $error("miss word with nonzero fields");

	// Weights never exceed one.
	a_weight_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bary_u <= BARY_W'(65536) && bary_v <= BARY_W'(65536))
		else $error("barycentric weight above one");

	// With no result waiting, the pipeline has room for a new word.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output is empty");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(dist_t)
			&& $stable(bary_u) && $stable(bary_v))
		else $error("stalled result changed");

endmodule

bind ray_triangle_intersection_top rti_chk u_rti_chk (.*);

/* dv/tb_ray_triangle_intersection_top.sv */
// Testbench for the ray/triangle intersection tester: directed and random rays
// are checked against a fixed-point intersection predictor. Depends on rti_pkg.
module tb_ray_triangle_intersection_top;
	import rti_pkg::*;

	localparam int LATENCY     = 39;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic signed [IN_W-1:0] ox, oy, oz, dx, dy, dz;
	} ray_t;

	typedef struct {
		logic                      hit;
		logic signed [OUT_T_W-1:0] t;
		logic [BARY_W-1:0]         u, v;
	} hit_rec_t;

	logic clk = 0, arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0, prdata;
	logic pready, in_valid = 0, in_stall, out_valid, out_stall = 0, hit;
	logic signed [IN_W-1:0] origin_x = 0, origin_y = 0, origin_z = 0;
	logic signed [IN_W-1:0] dir_x = 0, dir_y = 0, dir_z = 0;
	logic signed [OUT_T_W-1:0] dist_t;
	logic [BARY_W-1:0] bary_u, bary_v;

	// Shadow copy of the triangle registers.
	logic [CFG_W-1:0] vtx_a = '0, edg_ab = '0, edg_ac = '0;
	logic [EPS_W-1:0] eps = 41;

	hit_rec_t expected_hits[$];
	int errors = 0, cycles = 0;
	int idle_pct = 0, stall_pct = 0;

	ray_triangle_intersection_top uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic longint coord(logic [CFG_W-1:0] w, int k);
		logic signed [IN_W-1:0] f;
		f = w[IN_W*k +: IN_W];
		return longint'(f);
	endfunction

	// Sixteen fraction bits of r/d by restoring division, r < d.
	function automatic longint unsigned div_frac(longint unsigned r, longint unsigned d);
		longint unsigned q;
		q = 0;
		for (int i = 0; i < 16; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 1;
			end
		end
		return q;
	endfunction

	function automatic longint unsigned weight(longint unsigned n, longint unsigned d);
		return (n >= d) ? 65536 : div_frac(n, d);
	endfunction

	// Moller-Trumbore in the block's fixed-point formats.
	function automatic hit_rec_t trace_ray(ray_t r);
		longint a[3], e1[3], e2[3], o[3], d[3], s[3], p[3], q[3];
		longint det, un, vn, tn;
		longint unsigned dm, mag, ip, tq;
		hit_rec_t res;
		res = '{0, 0, 0, 0};
		for (int k = 0; k < 3; k++) begin
			a[k] = coord(vtx_a, k);
			e1[k] = coord(edg_ab, k);
			e2[k] = coord(edg_ac, k);
		end
		o = '{r.ox, r.oy, r.oz};
		d = '{r.dx, r.dy, r.dz};
		for (int k = 0; k < 3; k++) s[k] = o[k] - a[k];
		p[0] = (d[1]*e2[2] - d[2]*e2[1]) >>> 12;
		p[1] = (d[2]*e2[0] - d[0]*e2[2]) >>> 12;
		p[2] = (d[0]*e2[1] - d[1]*e2[0]) >>> 12;
		det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
		dm = det < 0 ? -det : det;
		if (det == 0 || dm < (longint'(eps) << 12)) return res;
		q[0] = (s[1]*e1[2] - s[2]*e1[1]) >>> 12;
		q[1] = (s[2]*e1[0] - s[0]*e1[2]) >>> 12;
		q[2] = (s[0]*e1[1] - s[1]*e1[0]) >>> 12;
		un = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
		vn = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
		tn = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
		if (det < 0) begin
			un = -un;
			vn = -vn;
			tn = -tn;
		end
		if (un < 0 || longint'(un) > longint'(dm)) return res;
		if (vn < 0 || longint'(un + vn) > longint'(dm)) return res;
		mag = tn < 0 ? -tn : tn;
		ip = mag / dm;
		if (ip >= 32768) begin
			res.t = tn < 0 ? 32'sh80000000 : 32'sh7FFFFFFF;
		end else begin
			tq = (ip << 16) | div_frac(mag - ip*dm, dm);
			res.t = tn < 0 ? -tq[31:0] : tq[31:0];
		end
		res.hit = 1;
		res.u = BARY_W'(weight(un, dm));
		res.v = BARY_W'(weight(vn, dm));
		return res;
	endfunction

	function automatic logic [CFG_W-1:0] pack3(longint x, longint y, longint z);
		logic [IN_W-1:0] fx, fy, fz;
		fx = IN_W'(x);
		fy = IN_W'(y);
		fz = IN_W'(z);
		return {fz, fy, fx};
	endfunction

	// One register write: setup cycle, then access cycle.
	task automatic cfg_write(reg_idx_t idx, logic [PDATA_W-1:0] val);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= PADDR_W'(8 * int'(idx));
		pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_VERTEX_A: vtx_a = val[CFG_W-1:0];
			REG_EDGE_AB:  edg_ab = val[CFG_W-1:0];
			REG_EDGE_AC:  edg_ac = val[CFG_W-1:0];
			REG_DET_EPS:  eps = val[EPS_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (expected_hits.size() != 0) @(posedge clk);
		repeat (LATENCY + 6) @(posedge clk);
	endtask

	task automatic set_triangle(logic [CFG_W-1:0] a, logic [CFG_W-1:0] ab,
			logic [CFG_W-1:0] ac, logic [EPS_W-1:0] e);
		drain();
		cfg_write(REG_VERTEX_A, a);
		cfg_write(REG_EDGE_AB, ab);
		cfg_write(REG_EDGE_AC, ac);
		cfg_write(REG_DET_EPS, e);
	endtask

	// Send one ray word and hold it until accepted, then maybe go idle.
	task automatic send_ray(ray_t r);
		origin_x <= r.ox;
		origin_y <= r.oy;
		origin_z <= r.oz;
		dir_x <= r.dx;
		dir_y <= r.dy;
		dir_z <= r.dz;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		expected_hits.push_back(trace_ray(r));
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Ray aimed at a random point of the triangle, with direction components sometimes negated or the direction halved.
	function automatic ray_t aimed_ray();
		ray_t r;
		longint o[3], tgt[3];
		int fu, fv;
		fu = $urandom_range(256);
		fv = $urandom_range(256 - fu);
		for (int k = 0; k < 3; k++) begin
			o[k] = longint'($signed($urandom_range(400000)) - 200000);
			tgt[k] = coord(vtx_a, k) + (coord(edg_ab, k)*fu + coord(edg_ac, k)*fv) / 256;
			tgt[k] = tgt[k] - o[k];
			if ($urandom_range(3) == 0) tgt[k] = -tgt[k];
		end
		r = '{IN_W'(o[0]), IN_W'(o[1]), IN_W'(o[2]),
			IN_W'(tgt[0]), IN_W'(tgt[1]), IN_W'(tgt[2])};
		if ($urandom_range(4) == 0) begin
			r.dx = r.dx >>> 1;
			r.dy = r.dy >>> 1;
			r.dz = r.dz >>> 1;
		end
		return r;
	endfunction

	function automatic ray_t noise_ray();
		ray_t r;
		r = '{IN_W'($urandom), IN_W'($urandom), IN_W'($urandom),
			IN_W'($urandom), IN_W'($urandom), IN_W'($urandom)};
		if ($urandom_range(1)) begin
			r.ox = r.ox >>> 4;
			r.oy = r.oy >>> 4;
			r.oz = r.oz >>> 4;
		end
		return r;
	endfunction

	task automatic run_random(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 75) send_ray(aimed_ray());
			else send_ray(noise_ray());
		end
		in_valid <= 0;
	endtask

	function automatic logic [CFG_W-1:0] rand_vec(int span);
		return pack3($signed($urandom_range(2*span)) - span,
			$signed($urandom_range(2*span)) - span,
			$signed($urandom_range(2*span)) - span);
	endfunction

	// Directed rays: degenerate, parallel, outside, corners, saturation, extremes.
	task automatic test_directed();
		localparam longint ONE = 4096;
		idle_pct = 0;
		stall_pct = 0;
		set_triangle(pack3(0, 0, 10*ONE), pack3(4*ONE, 0, 0), pack3(0, 4*ONE, 0), 41);
		send_ray('{ONE, ONE, 0, 0, 0, ONE});
		send_ray('{ONE, ONE, 0, 0, 0, -ONE});
		send_ray('{ONE, ONE, 20*ONE, 0, 0, ONE});
		send_ray('{ONE, ONE, 0, ONE, 0, 0});
		send_ray('{ONE, ONE, 0, 0, 0, 10});
		send_ray('{-ONE, ONE, 0, 0, 0, ONE});
		send_ray('{ONE, -ONE, 0, 0, 0, ONE});
		send_ray('{3*ONE, 3*ONE, 0, 0, 0, ONE});
		send_ray('{4*ONE, 0, 0, 0, 0, ONE});
		send_ray('{0, 4*ONE, 0, 0, 0, ONE});
		send_ray('{0, 0, 0, 0, 0, ONE});
		send_ray('{ONE, ONE, 0, 0, 0, 1});
		send_ray('{ONE, ONE, 20*ONE, 0, 0, -1});
		send_ray('{-1048576, -1048576, -1048576, 1048575, 1048575, 1048575});
		send_ray('{1048575, 1048575, 1048575, -1048576, -1048576, -1048576});
		send_ray('{0, 0, 0, 0, 0, 0});
		in_valid <= 0;
		// Zero determinant still misses with no threshold.
		set_triangle(pack3(0, 0, 10*ONE), pack3(4*ONE, 0, 0), pack3(0, 4*ONE, 0), 0);
		send_ray('{ONE, ONE, 0, ONE, 0, 0});
		send_ray('{ONE, ONE, 0, 0, 0, 1});
		send_ray('{ONE, ONE, 0, 0, 1, 0});
		in_valid <= 0;
		// Largest vertex and edge magnitudes.
		set_triangle(pack3(-1048576, 1048575, -1048576), pack3(1048575, -1048576, 1048575),
			pack3(-1048576, -1048576, 1048575), 41);
		send_ray('{0, 0, 0, 1048575, 1048575, 1048575});
		send_ray('{1048575, -1048576, 0, -1048576, 1048575, -1048576});
		in_valid <= 0;
	endtask

	task automatic test_streaming();
		idle_pct = 0;
		stall_pct = 0;
		set_triangle(rand_vec(200000), rand_vec(150000), rand_vec(150000), 0);
		run_random(160);
	endtask

	task automatic test_sender_gaps();
		idle_pct = 78;
		stall_pct = 0;
		set_triangle(rand_vec(200000), rand_vec(150000), rand_vec(150000), 41);
		run_random(120);
		// Hold off until the pipeline is empty, then resume.
		while (expected_hits.size() != 0) @(posedge clk);
		run_random(20);
	endtask

	task automatic test_receiver_stalls();
		idle_pct = 0;
		stall_pct = 78;
		set_triangle(rand_vec(200000), rand_vec(150000), rand_vec(150000),
			EPS_W'($urandom_range(2000)));
		run_random(130);
	endtask

	task automatic test_mixed_pressure();
		idle_pct = 12;
		stall_pct = 12;
		set_triangle(CFG_W'({$urandom, $urandom}), CFG_W'({$urandom, $urandom}),
			CFG_W'({$urandom, $urandom}), 20'hFFFFF);
		run_random(30);
		set_triangle(rand_vec(200000), rand_vec(150000), rand_vec(150000), 1);
		run_random(100);
	endtask

	// Receiver stall generator.
	always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	// Compare each delivered word with the oldest expectation.
	always @(posedge clk) begin
		hit_rec_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_hits.size() == 0) begin
				$display("%0t: unexpected result hit=%0b t=%0d u=%0d v=%0d", $time,
					hit, dist_t, bary_u, bary_v);
				errors++;
			end else begin
				want = expected_hits.pop_front();
				if (hit !== want.hit || dist_t !== want.t || bary_u !== want.u ||
						bary_v !== want.v) begin
					$display("%0t: expected hit=%0b t=%0d u=%0d v=%0d, got hit=%0b t=%0d u=%0d v=%0d",
						$time, want.hit, want.t, want.u, want.v, hit, dist_t, bary_u, bary_v);
					errors++;
				end
			end
		end
	end

	// Run timeout.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_streaming();
		test_sender_gaps();
		test_receiver_stalls();
		test_mixed_pressure();
		drain();
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
